// File: hw/rtl/u8u16_pkg.sv
// Shared types, codes and constants of the UTF-8 to UTF-16 decoder.
package u8u16_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int CFG_INDEX_W     = 1;
  localparam int CFG_DATA_W      = 16;
  localparam int UNIT_W          = 16;
  localparam int ACC_W           = 21;

  localparam logic [ACC_W-1:0]  SURR_OFFSET = 21'h10000;
  localparam logic [UNIT_W-1:0] HIGH_SURR   = 16'hD800;
  localparam logic [UNIT_W-1:0] LOW_SURR    = 16'hDC00;
  localparam logic [UNIT_W-1:0] TOTAL_MAX   = 16'hFFFF;
  localparam logic [10:0]       FOUR_LOW    = 11'h730;
  localparam logic [10:0]       FOUR_TOP    = 11'h400;
  localparam logic [10:0]       FOUR_HIGH   = 11'h330;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_STRICT_MODE   = 1'b0,
    REG_DEST_CAPACITY = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [1:0]        n_units;
    logic [UNIT_W-1:0] unit0;
    logic [UNIT_W-1:0] unit1;
    logic              fin;
    status_t           status;
    logic [UNIT_W-1:0] total;
  } bundle_t;

  function automatic logic [1:0] result_count(bundle_t bd);
    return bd.n_units + {1'b0, bd.fin};
  endfunction

endpackage

// File: hw/rtl/u8u16_if.sv
// Byte input and result output channel interfaces.
interface u8u16_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface u8u16_out_if;
  logic        valid;
  logic        ready;
  logic        is_final;
  logic [15:0] code_unit;
  logic [1:0]  status;
  logic [15:0] unit_total;
  logic        last_of_run;

  modport source (output valid, output is_final, output code_unit, output status,
                  output unit_total, output last_of_run, input ready);
  modport sink   (input valid, input is_final, input code_unit, input status,
                  input unit_total, input last_of_run, output ready);
endinterface

// File: hw/rtl/u8u16_decode.sv
// Per-byte decode state, configuration registers and result bundle logic.
module u8u16_decode #(
  parameter int COUNT_WIDTH = u8u16_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 take,
  input  logic [7:0]                           data_byte,
  input  logic                                 last_byte,
  input  logic                                 cfg_we,
  input  logic [u8u16_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [u8u16_pkg::CFG_DATA_W-1:0]     cfg_data,
  output u8u16_pkg::bundle_t                   bundle
);
  import u8u16_pkg::*;

  localparam int CMP_W = ((COUNT_WIDTH > 16) ? COUNT_WIDTH : 16) + 2;

  logic                   strict_mode;
  logic [15:0]            dest_capacity;
  logic [2:0]             trail_left, trail_left_next;
  logic [2:0]             seq_total, seq_total_next;
  logic [ACC_W-1:0]       code_accum, code_accum_next;
  logic                   form_ok, form_ok_next;
  logic [COUNT_WIDTH-1:0] unit_count, unit_count_next;
  logic                   swallow, swallow_next;
  status_t                fail_code, fail_code_next;

  logic                   fresh;
  logic                   dv;
  logic [1:0]             dk;
  logic [UNIT_W-1:0]      du0, du1;
  logic [10:0]            w;
  logic [19:0]            v;
  logic [CMP_W-1:0]       sum_ext;
  logic [CMP_W-1:0]       cnt_ext;
  logic                   is_trail;

  assign is_trail = (data_byte[7:6] == 2'b10);
  assign w        = {code_accum[2:0], data_byte};

  always_comb begin
    trail_left_next = trail_left;
    seq_total_next  = seq_total;
    code_accum_next = code_accum;
    form_ok_next    = form_ok;
    unit_count_next = unit_count;
    swallow_next    = swallow;
    fail_code_next  = fail_code;
    fresh           = 1'b0;
    dv              = 1'b0;
    dk              = 2'd0;
    du0             = '0;
    du1             = '0;
    v               = '0;
    sum_ext         = '0;
    cnt_ext         = '0;
    bundle          = '0;
    bundle.status   = ST_OK;

    if (!swallow) begin
      if (trail_left != 3'd0) begin
        if (is_trail) begin
          if (trail_left == seq_total) begin
            if (seq_total == 3'd2) begin
              if (code_accum[3:0] == 4'd0 && !data_byte[5]) form_ok_next = 1'b0;
            end else if (seq_total == 3'd3) begin
              if ((w & FOUR_LOW) == 11'd0 ||
                  ((w & FOUR_TOP) != 11'd0 && (w & FOUR_HIGH) != 11'd0)) begin
                form_ok_next = 1'b0;
              end
            end
          end
          if (trail_left == seq_total && !form_ok_next && strict_mode) begin
            swallow_next    = 1'b1;
            fail_code_next  = ST_INVALID;
            trail_left_next = 3'd0;
          end else begin
            code_accum_next = {code_accum[ACC_W-7:0], data_byte[5:0]};
            trail_left_next = trail_left - 3'd1;
            if (trail_left_next == 3'd0 && form_ok_next) begin
              dv = 1'b1;
              if (seq_total == 3'd3) begin
                v   = 20'(code_accum_next - SURR_OFFSET);
                dk  = 2'd2;
                du0 = UNIT_W'(v[19:10]) + HIGH_SURR;
                du1 = UNIT_W'(v[9:0]) + LOW_SURR;
              end else begin
                dk  = 2'd1;
                du0 = code_accum_next[UNIT_W-1:0];
              end
            end
          end
        end else if (strict_mode) begin
          swallow_next    = 1'b1;
          fail_code_next  = ST_INVALID;
          trail_left_next = 3'd0;
        end else begin
          trail_left_next = 3'd0;
          fresh           = 1'b1;
        end
      end else begin
        fresh = 1'b1;
      end

      if (fresh) begin
        if (!data_byte[7]) begin
          dv  = 1'b1;
          dk  = 2'd1;
          du0 = UNIT_W'(data_byte);
        end else if (is_trail) begin
          if (strict_mode) begin
            swallow_next    = 1'b1;
            fail_code_next  = ST_INVALID;
            trail_left_next = 3'd0;
          end
        end else begin
          unique casez (data_byte)
            8'b110?????: seq_total_next = 3'd1;
            8'b1110????: seq_total_next = 3'd2;
            8'b11110???: seq_total_next = 3'd3;
            8'b111110??: seq_total_next = 3'd4;
            8'b1111110?: seq_total_next = 3'd5;
            8'b11111110: seq_total_next = 3'd6;
            default:     seq_total_next = 3'd7;
          endcase
          trail_left_next = seq_total_next;
          code_accum_next = ACC_W'(data_byte & (8'h3F >> seq_total_next));
          if (seq_total_next == 3'd1) form_ok_next = (code_accum_next[4:1] != 4'd0);
          else                        form_ok_next = (seq_total_next <= 3'd3);
          if (!form_ok_next && strict_mode) begin
            swallow_next    = 1'b1;
            fail_code_next  = ST_INVALID;
            trail_left_next = 3'd0;
          end
        end
      end

      if (dv) begin
        sum_ext = CMP_W'(unit_count) + CMP_W'(dk);
        if (dest_capacity != 16'd0 && sum_ext > CMP_W'(dest_capacity)) begin
          swallow_next    = 1'b1;
          fail_code_next  = ST_OVERFLOW;
          trail_left_next = 3'd0;
        end else begin
          if (dest_capacity != 16'd0) begin
            bundle.n_units = dk;
            bundle.unit0   = du0;
            bundle.unit1   = du1;
          end
          unit_count_next = (sum_ext > CMP_W'({COUNT_WIDTH{1'b1}})) ?
                            {COUNT_WIDTH{1'b1}} : sum_ext[COUNT_WIDTH-1:0];
        end
      end
    end

    if (last_byte) begin
      if (!swallow_next && trail_left_next != 3'd0 && strict_mode) begin
        fail_code_next = ST_INVALID;
      end
      cnt_ext       = CMP_W'(unit_count_next);
      bundle.fin    = 1'b1;
      bundle.status = fail_code_next;
      if (fail_code_next != ST_OK)             bundle.total = '0;
      else if (cnt_ext > CMP_W'(TOTAL_MAX))    bundle.total = TOTAL_MAX;
      else                                     bundle.total = cnt_ext[UNIT_W-1:0];
      trail_left_next = '0;
      seq_total_next  = '0;
      code_accum_next = '0;
      form_ok_next    = 1'b0;
      unit_count_next = '0;
      swallow_next    = 1'b0;
      fail_code_next  = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strict_mode   <= 1'b0;
      dest_capacity <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STRICT_MODE:   strict_mode   <= cfg_data[0];
        REG_DEST_CAPACITY: dest_capacity <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trail_left <= '0;
      seq_total  <= '0;
      code_accum <= '0;
      form_ok    <= 1'b0;
      unit_count <= '0;
      swallow    <= 1'b0;
      fail_code  <= ST_OK;
    end else if (take) begin
      trail_left <= trail_left_next;
      seq_total  <= seq_total_next;
      code_accum <= code_accum_next;
      form_ok    <= form_ok_next;
      unit_count <= unit_count_next;
      swallow    <= swallow_next;
      fail_code  <= fail_code_next;
    end
  end

endmodule

// File: hw/rtl/u8u16_emit.sv
// Two-slot result bundle queue that sends one result per transaction.
module u8u16_emit (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  u8u16_pkg::bundle_t bundle,
  output logic               take_ready,
  u8u16_out_if.source        out
);
  import u8u16_pkg::*;

  bundle_t    slot_a, slot_b;
  logic       a_valid, b_valid;
  logic [1:0] idx;
  logic       push, b_last, b_done, b_free;

  assign push       = take && (result_count(bundle) != 2'd0);
  assign b_last     = (idx == result_count(slot_b) - 2'd1);
  assign b_done     = b_valid && out.ready && b_last;
  assign b_free     = !b_valid || b_done;
  assign take_ready = !a_valid || b_free;

  assign out.valid       = b_valid;
  assign out.is_final    = (idx >= slot_b.n_units);
  assign out.code_unit   = (idx >= slot_b.n_units) ? '0 :
                           ((idx == 2'd0) ? slot_b.unit0 : slot_b.unit1);
  assign out.status      = (idx >= slot_b.n_units) ? slot_b.status : ST_OK;
  assign out.unit_total  = (idx >= slot_b.n_units) ? slot_b.total : '0;
  assign out.last_of_run = b_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      idx     <= '0;
    end else if (b_free) begin
      idx <= '0;
      if (a_valid) begin
        b_valid <= 1'b1;
        a_valid <= push;
      end else begin
        b_valid <= push;
      end
    end else begin
      if (push) a_valid <= 1'b1;
      if (out.ready) idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (b_free) begin
      if (a_valid) begin
        slot_b <= slot_a;
        if (push) slot_a <= bundle;
      end else if (push) begin
        slot_b <= bundle;
      end
    end else if (push) begin
      slot_a <= bundle;
    end
  end

endmodule

// File: hw/rtl/utf8_to_utf16_decoder_unit.sv
// Top level of the UTF-8 to UTF-16 decoder.
//
//   channel   direction  payload
//   byte_in   sink       data_byte, last_byte
//   unit_out  source     is_final, code_unit, status, unit_total, last_of_run
//   cfg       write      cfg_we, cfg_index, cfg_data
//
// A byte is decoded in the cycle it is accepted; its results appear one per
// cycle while unit_out is ready. A byte gives zero to three results, so the
// sustained rate, with no stall, is one byte per cycle, or one per result
// where a byte gives more than one; the single-result output port sets that
// figure. A two-bundle queue lets a new byte enter while a result is stalled.
// Reset is synchronous and clears all decode state and the queue.
module utf8_to_utf16_decoder_unit #(
  parameter int COUNT_WIDTH = u8u16_pkg::COUNT_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  u8u16_in_if.sink                          byte_in,
  u8u16_out_if.source                       unit_out,
  input  logic                              cfg_we,
  input  logic [u8u16_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [u8u16_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import u8u16_pkg::*;

  bundle_t bundle;
  logic    take;
  logic    take_ready;

  assign byte_in.ready = take_ready;
  assign take          = byte_in.valid && take_ready;

  u8u16_decode #(.COUNT_WIDTH(COUNT_WIDTH)) u_decode (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .data_byte (byte_in.data_byte),
    .last_byte (byte_in.last_byte),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .bundle    (bundle)
  );

  u8u16_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .bundle     (bundle),
    .take_ready (take_ready),
    .out        (unit_out)
  );

endmodule

// File: hw/rtl/u8u16_check.sv
// Port-level assertions for the decoder top level, with their bind.
module u8u16_check (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        is_final,
  input logic [15:0] code_unit,
  input logic [1:0]  status,
  input logic [15:0] unit_total,
  input logic        last_of_run
);
  import u8u16_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(is_final) && $stable(code_unit)
      && $stable(status) && $stable(unit_total) && $stable(last_of_run))
    else $error("result changed while stalled");

  a_final_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_final |-> last_of_run)
    else $error("end-of-string result is not last of its run");

  a_error_total: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> is_final && unit_total == 16'd0)
    else $error("error status on a code unit or with a count");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind utf8_to_utf16_decoder_unit u8u16_check u_check (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (unit_out.valid),
  .out_ready   (unit_out.ready),
  .is_final    (unit_out.is_final),
  .code_unit   (unit_out.code_unit),
  .status      (unit_out.status),
  .unit_total  (unit_out.unit_total),
  .last_of_run (unit_out.last_of_run)
);
